### src/ipnf_pkg.sv
// ============================================================================
// ipnf_pkg
// Shared types and constants for the isolated pixel noise filter.
// ============================================================================
package ipnf_pkg;

    // Grey codes and the width of one code.
    localparam int unsigned LEVEL_BITS = 2;
    localparam logic [LEVEL_BITS-1:0] LEVEL_WHITE = 2'd0;

    // Frame width register.
    localparam int unsigned FW_BITS = 11;
    localparam logic [FW_BITS-1:0] FW_RESET = 11'd64;

    // Row context saturates at this count.
    localparam logic [1:0] ROW_SAT = 2'd3;

    // Stream bit widths.
    localparam int unsigned S_TDATA_BITS = 8;
    localparam int unsigned S_TUSER_BITS = 2;
    localparam int unsigned M_TDATA_BITS = 8;
    localparam int unsigned M_TUSER_BITS = 1;

    typedef logic [LEVEL_BITS-1:0] level_t;

    // One memory entry holds three consecutive codes, the newest in the low bits.
    typedef logic [3*LEVEL_BITS-1:0] triple_t;

    // Border guards and frame marker of one center pixel.
    typedef struct packed {
        logic up;
        logic left;
        logic right;
        logic first;
    } win_guard_t;

endpackage

### src/isolated_pixel_noise_filter_unit.sv
// ============================================================================
// isolated_pixel_noise_filter_unit
// 3x3 isolated dark pixel removal on a stream of 2-bit grey codes.
// ============================================================================
//
// Usage:
//   Pixels enter on the s_ stream in row order, one per transfer. A pixel with
//   frame_start set begins a new frame and clears the row and column context.
//   Each pixel is thresholded (white and light grey become white); a dark or
//   black pixel whose eight neighbors are all white is replaced by white.
//   Outside the frame counts as white. The result for a pixel is produced once
//   width+1 further pixels of the frame have entered, so the sender appends
//   width+1 pad transfers to flush the last row.
//   Results leave on the m_ stream; first_of_frame marks the frame's first one.
//   frame_width is written through cfg_we/cfg_wdata while the block is idle;
//   the user is bound to this, as the block itself does not enforce it.
//   Throughput is one pixel per clock while the receiver accepts results. A
//   result is registered in the read stage, for the synchronous read of the row memory, then in the output register.
//   The row memory has one write and two read ports; each entry packs three
//   neighboring codes, so two reads fetch the upper and middle window rows.
//   Reset clears all counters and acts as a frame start; the memory needs no
//   clearing pass because border guards keep unwritten entries out of results.
//   When the receiver stalls, the read stage and the output register both
//   hold, and s_tready falls only once both are full.
//
module isolated_pixel_noise_filter_unit #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: frame_width.
    input  logic                                cfg_we,
    input  logic [ipnf_pkg::FW_BITS-1:0]        cfg_wdata,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ipnf_pkg::S_TDATA_BITS-1:0]   s_tdata,   // [1:0] pixel_level
    input  logic [ipnf_pkg::S_TUSER_BITS-1:0]   s_tuser,   // [0] pad, [1] frame_start
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ipnf_pkg::M_TDATA_BITS-1:0]   m_tdata,   // [1:0] clean_level
    output logic [ipnf_pkg::M_TUSER_BITS-1:0]   m_tuser    // [0] first_of_frame
);
    import ipnf_pkg::*;

    // Width of the effective row width (1..MAX_WIDTH).
    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
    // Width used to compare the raw register against MAX_WIDTH.
    localparam int unsigned CW    = (WW > FW_BITS) ? WW : FW_BITS;
    // Position counter runs up to width+1.
    localparam int unsigned PW    = $clog2(MAX_WIDTH + 2);
    // Column counter stays below the width.
    localparam int unsigned CLW   = $clog2(MAX_WIDTH);
    // History ring must reach back 2*width+2 items.
    localparam int unsigned AW    = $clog2(2 * MAX_WIDTH + 3);
    localparam int unsigned DEPTH = 1 << AW;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [FW_BITS-1:0] frame_width_reg;
    logic [AW-1:0]      head_reg,   head_next;
    logic [PW-1:0]      pos_reg,    pos_next;
    logic [CLW-1:0]     col_reg,    col_next;
    logic [1:0]         row_reg,    row_next;
    level_t             hist1_reg;   // code that entered one item ago
    level_t             hist2_reg;   // code that entered two items ago

    // Read stage: waits for the memory data.
    logic               s1_valid_reg;
    win_guard_t         s1_guard_reg, s1_guard_next;
    level_t             s1_d0_reg, s1_d1_reg, s1_d2_reg;

    // Output register.
    logic               out_valid_reg;
    level_t             out_level_reg, out_level_next;
    logic               out_first_reg;

    // Row memory.
    triple_t            row_mem [DEPTH];
    triple_t            rd_mid_reg;  // codes at back distances w, w+1, w+2
    triple_t            rd_top_reg;  // codes at back distances 2w, 2w+1, 2w+2

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_xfer, out_xfer, s1_move, has_result;

    assign out_xfer = out_valid_reg & m_tready;
    assign s1_move  = s1_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~s1_valid_reg | ~out_valid_reg | m_tready;
    assign in_xfer  = s_tvalid & s_tready;

    // ------------------------------------------------------------------
    // Input decode and effective width
    // ------------------------------------------------------------------
    level_t        pix_level;
    logic          pix_pad, pix_fs;
    level_t        pix_code;
    logic [CW-1:0] fw_ext;
    logic [WW-1:0] eff_w;

    assign pix_level = s_tdata[LEVEL_BITS-1:0];
    assign pix_pad   = s_tuser[0];
    assign pix_fs    = s_tuser[1];
    // Threshold: dark grey and black keep their code, everything else is white.
    assign pix_code  = (!pix_pad && pix_level[1]) ? pix_level : LEVEL_WHITE;
    assign fw_ext    = CW'(frame_width_reg);

    always_comb
    begin
        if (fw_ext == '0)
        begin
            eff_w = WW'(1);
        end
        else if (fw_ext > CW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(fw_ext);
        end
    end

    // ------------------------------------------------------------------
    // Position, column and row tracking
    // ------------------------------------------------------------------
    logic [PW-1:0]  pos_c;
    logic [CLW-1:0] col_c, col_a;
    logic [1:0]     row_c, row_a;
    logic [WW-1:0]  col_inc;

    always_comb
    begin
        pos_c = pix_fs ? '0 : pos_reg;
        col_c = pix_fs ? '0 : col_reg;
        row_c = pix_fs ? '0 : row_reg;

        has_result    = 1'b0;
        pos_next      = pos_c;
        col_next      = col_c;
        row_next      = row_c;
        col_a         = col_c;
        row_a         = row_c;
        col_inc       = '0;
        s1_guard_next = '0;

        if (pos_c <= PW'(eff_w))
        begin
            // Still filling the first row plus one pixel of the frame.
            pos_next = pos_c + PW'(1);
        end
        else
        begin
            has_result = 1'b1;
            // A narrowed width can leave the column at or past the row end.
            if (WW'(col_c) >= eff_w)
            begin
                col_a = '0;
                row_a = (row_c == ROW_SAT) ? row_c : row_c + 2'd1;
            end
            s1_guard_next.up    = (row_a != 2'd0);
            s1_guard_next.left  = (col_a != '0);
            s1_guard_next.right = ((WW'(col_a) + WW'(1)) < eff_w);
            s1_guard_next.first = (row_a == 2'd0) && (col_a == '0);

            col_inc = WW'(col_a) + WW'(1);
            if (col_inc >= eff_w)
            begin
                col_next = '0;
                row_next = (row_a == ROW_SAT) ? row_a : row_a + 2'd1;
            end
            else
            begin
                col_next = CLW'(col_inc);
                row_next = row_a;
            end
        end
    end

    // ------------------------------------------------------------------
    // Row memory: write the newest triple, read the two upper rows
    // ------------------------------------------------------------------
    logic [AW-1:0] w_off, w2_off, rd_mid_addr, rd_top_addr;

    assign head_next   = head_reg + AW'(1);
    assign w_off       = AW'(eff_w);
    assign w2_off      = w_off << 1;
    assign rd_mid_addr = head_next - w_off;
    assign rd_top_addr = head_next - w2_off;

    // Read addresses always trail the write address by at least one entry,
    // and a write lands before the next item's read, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            row_mem[head_next] <= {hist2_reg, hist1_reg, pix_code};
            rd_mid_reg         <= row_mem[rd_mid_addr];
            rd_top_reg         <= row_mem[rd_top_addr];
        end
    end

    // ------------------------------------------------------------------
    // Window assembly and isolation test
    // ------------------------------------------------------------------
    level_t win_tl, win_tc, win_tr, win_ml, win_mc, win_mr, win_bl, win_bc, win_br;
    logic   isolated;

    always_comb
    begin
        win_tl = (s1_guard_reg.up && s1_guard_reg.left)  ? rd_top_reg[5:4] : LEVEL_WHITE;
        win_tc =  s1_guard_reg.up                        ? rd_top_reg[3:2] : LEVEL_WHITE;
        win_tr = (s1_guard_reg.up && s1_guard_reg.right) ? rd_top_reg[1:0] : LEVEL_WHITE;
        win_ml =  s1_guard_reg.left  ? rd_mid_reg[5:4] : LEVEL_WHITE;
        win_mc =  rd_mid_reg[3:2];
        win_mr =  s1_guard_reg.right ? rd_mid_reg[1:0] : LEVEL_WHITE;
        win_bl =  s1_guard_reg.left  ? s1_d2_reg : LEVEL_WHITE;
        win_bc =  s1_d1_reg;
        win_br =  s1_guard_reg.right ? s1_d0_reg : LEVEL_WHITE;

        isolated = ~|{win_tl, win_tc, win_tr, win_ml, win_mr, win_bl, win_bc, win_br};
        out_level_next = isolated ? LEVEL_WHITE : win_mc;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FW_RESET;
            head_reg        <= '0;
            pos_reg         <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            hist1_reg       <= LEVEL_WHITE;
            hist2_reg       <= LEVEL_WHITE;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_width_reg <= cfg_wdata;
            end
            if (in_xfer)
            begin
                head_reg  <= head_next;
                pos_reg   <= pos_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
                hist1_reg <= pix_code;
                hist2_reg <= hist1_reg;
            end
            if (in_xfer)
            begin
                s1_valid_reg <= has_result;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_guard_reg <= s1_guard_next;
            s1_d0_reg    <= pix_code;
            s1_d1_reg    <= hist1_reg;
            s1_d2_reg    <= hist2_reg;
        end
        if (s1_move)
        begin
            out_level_reg <= out_level_next;
            out_first_reg <= s1_guard_reg.first;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'(out_level_reg);
    assign m_tuser  = out_first_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while the output register is empty");

    a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> s1_valid_reg)
        else $error("pending result dropped from the read stage");

    a_head_advances: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (head_reg == $past(head_reg) + AW'(1)))
        else $error("history head did not advance by one per transfer");

    a_no_light_grey_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_level_reg != LEVEL_WHITE) |-> out_level_reg[1])
        else $error("light grey code on the output");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && has_result) |=> (WW'(col_reg) < $past(eff_w)))
        else $error("column counter past the row end");

endmodule
